>>> rtl/bfiq_pkg.sv
// Shared constants, types and hash step functions for the bloom filter block.
package bfiq_pkg;

	localparam int unsigned MAX_BITS_DEF = 4096;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam int unsigned PROBES_W = 5;
	localparam int unsigned FILTER_BYTES_W = 10;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [4:0] PROBES_RST = 5'd3;
	localparam logic [9:0] FILTER_BYTES_RST = 10'd512;

	typedef enum logic [0:0] {
		CFG_PROBES = 1'b0,
		CFG_FILTER_BYTES = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// FNV-1a byte step
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

	// one-at-a-time byte step
	function automatic logic [31:0] oaat_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h + {24'd0, b};
		x = x + (x << 10);
		x = x ^ (x >> 6);
		return x;
	endfunction

	function automatic logic [31:0] oaat_final(input logic [31:0] h);
		logic [31:0] x;
		x = h + (h << 3);
		x = x ^ (x >> 11);
		x = x + (x << 15);
		return (x == 32'd0) ? 32'd1 : x;
	endfunction

endpackage

>>> rtl/bloom_filter_insert_query_top.sv
// Top level of the bloom filter insert and query block.
// Usage:
//   Input channel (in_valid/in_ready) carries one key byte per item with
//   mode and last_byte. Bytes that are not last produce no result; they are
//   registered, then folded into the FNV-1a and one-at-a-time hashes in the
//   multiply step.
//   On a last byte the block finishes the hashes, then runs one probe per
//   configured count. Each probe takes a modulo from the shared serial
//   divider, a memory read, and for inserts a write back.
//   A query stops at the first clear bit.
//   Output channel (out_valid/out_ready) presents maybe_present and
//   was_insert from an output register; a stalled receiver holds it, and
//   the next byte is still taken while the result waits. A following
//   last byte waits for the result slot to drain.
//   Reset: the bit store is cleared by a pass over its MAX_BITS/8 rows,
//   one byte row per cycle, during which no item is taken. Configuration
//   writes (cfg_we/cfg_idx/cfg_data) are taken at any time.
//   Probes run strictly one after another, so reads never overlap writes.
module bloom_filter_insert_query_top #(
	parameter int unsigned MAX_BITS = bfiq_pkg::MAX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [7:0] key_byte,
	input  logic last_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic maybe_present,
	output logic was_insert
);
	localparam int unsigned ROWS = MAX_BITS / 8;
	localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned BW = $clog2(MAX_BITS) + 1;
	localparam int unsigned MAXFB = ROWS;

	logic [7:0] mem [ROWS];
	logic [7:0] rdata_q;

	logic [bfiq_pkg::PROBES_W-1:0] probes_q;
	logic [bfiq_pkg::FILTER_BYTES_W-1:0] filter_bytes_q;
	logic [31:0] fnv_q, oaat_q, h2_q;
	logic [7:0] byte_q;
	logic mode_q, last_q;
	logic [4:0] pidx_q;
	logic [32:0] acc_q;
	logic [BW-1:0] nbits_q;
	logic [BW-1:0] idx_q;
	logic present_q;
	logic [AW-1:0] clr_q;
	bfiq_pkg::state_t state_q, state_d;

	logic mod_start, mod_done;
	logic [BW-1:0] mod_rem;
	logic [BW-1:0] nbits_d;

	// clamp filter size into its usable range
	always_comb begin
		if (filter_bytes_q < 10'd8) begin
			nbits_d = BW'(64);
		end else if (32'(filter_bytes_q) > MAXFB) begin
			nbits_d = BW'(MAX_BITS / 8 * 8);
		end else begin
			nbits_d = BW'({filter_bytes_q, 3'b000});
		end
	end

	bfiq_mod #(.DW(BW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(acc_q),
		.divisor(nbits_q), .done(mod_done), .remainder(mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probes_q <= bfiq_pkg::PROBES_RST;
			filter_bytes_q <= bfiq_pkg::FILTER_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				bfiq_pkg::CFG_PROBES: probes_q <= cfg_data[bfiq_pkg::PROBES_W-1:0];
				bfiq_pkg::CFG_FILTER_BYTES: filter_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfiq_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mod_start = 1'b0;
		case (state_q)
			bfiq_pkg::ST_CLEAR: begin
				if (clr_q == AW'(ROWS - 1)) state_d = bfiq_pkg::ST_IDLE;
			end
			bfiq_pkg::ST_IDLE: begin
				in_ready = !(last_byte && out_valid);
				if (in_valid && in_ready) state_d = bfiq_pkg::ST_MIX;
			end
			bfiq_pkg::ST_MIX: begin
				if (!last_q) state_d = bfiq_pkg::ST_IDLE;
				else if (probes_q == 5'd0) state_d = bfiq_pkg::ST_DONE;
				else state_d = bfiq_pkg::ST_DONE;
			end
			bfiq_pkg::ST_DONE: begin
				// entered from the finishing step and after each check: launch a probe or finish
				if (pidx_q < probes_q && (present_q || !mode_q)) begin
					mod_start = 1'b1;
					state_d = bfiq_pkg::ST_MOD;
				end else begin
					state_d = bfiq_pkg::ST_IDLE;
				end
			end
			bfiq_pkg::ST_MOD: begin
				if (mod_done) state_d = bfiq_pkg::ST_READ;
			end
			bfiq_pkg::ST_READ: state_d = bfiq_pkg::ST_CHECK;
			bfiq_pkg::ST_CHECK: state_d = bfiq_pkg::ST_DONE;
			default: state_d = bfiq_pkg::ST_IDLE;
		endcase
	end

	// hashes, clear counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnv_q <= bfiq_pkg::FNV_BASIS;
			oaat_q <= '0;
			clr_q <= '0;
			out_valid <= 1'b0;
			maybe_present <= 1'b0;
			was_insert <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == bfiq_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == bfiq_pkg::ST_MIX) begin
				if (last_q) begin
					fnv_q <= bfiq_pkg::FNV_BASIS;
					oaat_q <= '0;
				end else begin
					fnv_q <= bfiq_pkg::fnv_step(fnv_q, byte_q);
					oaat_q <= bfiq_pkg::oaat_step(oaat_q, byte_q);
				end
			end
			if (state_q == bfiq_pkg::ST_DONE &&
			    !(pidx_q < probes_q && (present_q || !mode_q))) begin
				out_valid <= 1'b1;
				maybe_present <= mode_q ? present_q : 1'b1;
				was_insert <= !mode_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q <= key_byte;
			mode_q <= mode;
			last_q <= last_byte;
		end
		if (state_q == bfiq_pkg::ST_MIX && last_q) begin
			h2_q <= bfiq_pkg::oaat_step(oaat_q, byte_q);
			acc_q <= {1'b0, bfiq_pkg::fnv_step(fnv_q, byte_q)};
			nbits_q <= nbits_d;
			pidx_q <= '0;
			present_q <= 1'b1;
		end
		// apply the final mix while the first probe reads; h2 is first used on check
		if (state_q == bfiq_pkg::ST_READ && pidx_q == 5'd0) begin
			h2_q <= bfiq_pkg::oaat_final(h2_q);
		end
		if (state_q == bfiq_pkg::ST_MOD && mod_done) idx_q <= mod_rem;
		if (state_q == bfiq_pkg::ST_CHECK) begin
			pidx_q <= pidx_q + 1'b1;
			// next dividend: (h1 + i*h2) mod n == (prev_rem + h2) mod n
			acc_q <= {{(33-BW){1'b0}}, idx_q} + {1'b0, h2_q};
			if (mode_q && !rdata_q[idx_q[2:0]]) present_q <= 1'b0;
		end
	end

	// bit store: one read port, one write port
	always_ff @(posedge clk) begin
		if (state_q == bfiq_pkg::ST_CLEAR) begin
			mem[clr_q] <= 8'd0;
		end else if (state_q == bfiq_pkg::ST_CHECK && !mode_q) begin
			mem[idx_q[AW+2:3]] <= rdata_q | (8'd1 << idx_q[2:0]);
		end
		rdata_q <= mem[idx_q[AW+2:3]];
	end
endmodule

>>> rtl/bfiq_mod.sv
// Iterative 33-bit by DW-bit modulo unit, one quotient bit per cycle.
module bfiq_mod #(
	parameter int unsigned DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [32:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] remainder
);
	localparam int unsigned CW = 6;

	logic [32:0]   num_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW+1:0] shifted;
	logic [DW+1:0] diff;

	assign shifted = {rem_q, num_q[32]};
	assign diff = shifted - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(33);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], 1'b0};
			// subtract when the shifted remainder reaches the divisor
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
			end else begin
				rem_q <= shifted[DW:0];
			end
		end
	end

	assign remainder = rem_q[DW-1:0];
endmodule

>>> rtl/bfiq_checker.sv
// Port-level checker for the bloom filter block, bound to the top level.
module bfiq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic last_byte,
	input logic out_valid,
	input logic out_ready,
	input logic maybe_present,
	input logic was_insert
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(maybe_present) && $stable(was_insert))
		else $error("result changed while stalled");
	a_insert_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_insert |-> maybe_present)
		else $error("insert reported absent");
	a_nonlast_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_byte && !out_valid |=> ##1 !out_valid)
		else $error("result after a non-final byte");
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result during reset");
endmodule

bind bloom_filter_insert_query_top bfiq_checker u_bfiq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.last_byte(last_byte), .out_valid(out_valid), .out_ready(out_ready),
	.maybe_present(maybe_present), .was_insert(was_insert)
);
